>>> design/cnla_pkg.sv
// Shared constants and types for the causal neighbour local average block.
`default_nettype none

package cnla_pkg;

  // Line buffer depth and band height limits.
  localparam int MAX_ROW_LEN = 1024;
  localparam int MAX_ROWS    = 1024;

  // Field and counter widths.
  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int COL_W = $clog2(MAX_ROW_LEN);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(320);

  // Request from the filter to the line buffer for one transfer.
  typedef struct packed {
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
  } lb_req_t;

endpackage

`default_nettype wire

>>> design/cnla_line_buffer.sv
// One-row line buffer with one write port and one registered read port.
`default_nettype none

module cnla_line_buffer (
  input  wire logic                    clk,
  input  wire cnla_pkg::lb_req_t       req,
  output logic [cnla_pkg::PIX_W-1:0]   rd_data
);
  import cnla_pkg::*;

  logic [PIX_W-1:0] mem [MAX_ROW_LEN];

  // Write, and read with the new data forwarded when both hit one address.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
        rd_data <= req.wr_data;
      end else begin
        rd_data <= mem[req.rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/causal_neighbour_local_average.sv
// Top level of the causal neighbour local average filter.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    sample
//   output   out        out_valid / out_ready  local_mean, band_end
//   config   in         write_enable           register_index, write_data
//
// One sample is accepted per cycle unless a result stalls; its result appears in
// the output register on the following cycle. The single line buffer read port
// sets this rate: the north-east neighbour of the next column is read while the
// current one is accepted. A stalled result holds the output register and blocks
// new input only while it is not taken. Reset clears the counters and the west and
// north-west window registers; the line buffer needs no clearing pass.
`default_nettype none

module causal_neighbour_local_average (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cnla_pkg::PIX_W-1:0]  sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cnla_pkg::PIX_W-1:0]       local_mean,
  output logic                             band_end,
  input  wire logic                        write_enable,
  input  wire logic                        register_index,
  input  wire logic [cnla_pkg::CFG_W-1:0]  write_data
);
  import cnla_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] west_sample;
  logic [PIX_W-1:0] north_west_sample;
  logic [PIX_W-1:0] north_sample;
  logic [PIX_W-1:0] row_start;
  logic [PIX_W-1:0] north_east_sample;
  logic             out_valid_next;

  logic             accept;
  logic [CFG_W-1:0] width_used;
  logic [CFG_W-1:0] height_used;
  logic             last_col;
  logic             last_row;
  lb_req_t          lb_req;

  logic [CFG_W-1:0] sum5;
  logic [CFG_W-1:0] sum4;
  logic [CFG_W-1:0] sum3;
  logic [PIX_W:0]   sum2;
  logic [22:0]      prod5;
  logic [22:0]      prod3;
  logic [PIX_W-1:0] mean;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (write_enable) begin
      case (register_index)
        REG_IMAGE_WIDTH:  image_width  <= write_data;
        REG_IMAGE_HEIGHT: image_height <= write_data;
        default: ;
      endcase
    end
  end

  // Saturate the programmed sizes to the supported range.
  always_comb begin
    if (image_width < CFG_W'(2)) begin
      width_used = CFG_W'(2);
    end else if (image_width > CFG_W'(MAX_ROW_LEN)) begin
      width_used = CFG_W'(MAX_ROW_LEN);
    end else begin
      width_used = image_width;
    end
    if (image_height < CFG_W'(1)) begin
      height_used = CFG_W'(1);
    end else if (image_height > CFG_W'(MAX_ROWS)) begin
      height_used = CFG_W'(MAX_ROWS);
    end else begin
      height_used = image_height;
    end
  end

  // A counter at or past the bound counts as the last position.
  assign last_col = CFG_W'(column_count) >= (width_used - CFG_W'(1));
  assign last_row = CFG_W'(row_count) >= (height_used - CFG_W'(1));

  // Store the sample and fetch the north-east neighbour of the next column.
  always_comb begin
    lb_req.wr_en   = accept;
    lb_req.wr_addr = column_count;
    lb_req.wr_data = sample;
    lb_req.rd_en   = accept;
    if (last_col) begin
      lb_req.rd_addr = COL_W'(1);
    end else begin
      lb_req.rd_addr = column_count + COL_W'(2);
    end
  end

  cnla_line_buffer u_line_buffer (
    .clk     (clk),
    .req     (lb_req),
    .rd_data (north_east_sample)
  );

  // Neighbour sums; divide by 3 and 5 via reciprocal products, by 2 and 4 via shifts.
  always_comb begin
    sum2  = {1'b0, sample} + {1'b0, west_sample};
    sum3  = CFG_W'(sample) + CFG_W'(north_sample) + CFG_W'(north_east_sample);
    sum4  = CFG_W'(sample) + CFG_W'(west_sample) + CFG_W'(north_west_sample)
          + CFG_W'(north_sample);
    sum5  = sum4 + CFG_W'(north_east_sample);
    prod5 = 23'(sum5) * 23'(3277);
    prod3 = 23'(sum3) * 23'(2731);
    if (row_count == '0) begin
      if (column_count == '0) begin
        mean = sample;
      end else begin
        mean = sum2[PIX_W:1];
      end
    end else if (column_count == '0) begin
      mean = prod3[20:13];
    end else if (!last_col) begin
      mean = prod5[21:14];
    end else begin
      mean = sum4[PIX_W+1:2];
    end
  end

  // Position counters and window registers advance on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= '0;
      row_count         <= '0;
      west_sample       <= '0;
      north_west_sample <= '0;
    end else if (accept) begin
      west_sample       <= sample;
      north_west_sample <= north_sample;
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // North neighbour of the next column; at a row wrap it is the row's first sample.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (column_count == '0) begin
        row_start <= sample;
      end
      if (last_col) begin
        north_sample <= row_start;
      end else begin
        north_sample <= north_east_sample;
      end
    end
  end

  // Output register.
  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      local_mean <= mean;
      band_end   <= last_col && last_row;
    end
  end

endmodule

`default_nettype wire

>>> design/cnla_checker.sv
// Port-level checks for the causal neighbour local average filter, with bind.
`default_nettype none

module cnla_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cnla_pkg::PIX_W-1:0]  local_mean,
  input wire logic                        band_end
);
  import cnla_pkg::*;

  // A result that is not taken stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(local_mean) && $stable(band_end))
    else $error("stalled result changed or vanished");

  // With the output register empty the block must take input.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output register is empty");

  // Every input transfer yields a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer produced no result");

  // No result is offered straight after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind causal_neighbour_local_average cnla_checker u_cnla_checker (.*);

`default_nettype wire

>>> tb/tb_causal_neighbour_local_average.sv
// Self-checking testbench for the causal neighbour local average filter.
`default_nettype none

module tb_causal_neighbour_local_average;
  import cnla_pkg::*;

  localparam int STALL_LIMIT      = 5000;
  localparam int DRAIN_CYCLES     = 4;
  localparam int RANDOM_ITEMS     = 1900;
  localparam int SHOWN_MISMATCHES = 10;

  // Receiver behaviour for one phase.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One sample to send; a fixed item carries a typed-in expected result.
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             fixed;
    logic [PIX_W-1:0] mean;
    logic             last;
  } px_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             last;
  } mean_t;

  // One row of the directed table: a register write or a sample.
  typedef struct packed {
    logic             is_cfg;
    logic             idx;
    logic [CFG_W-1:0] value;
    px_item_t         item;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic [PIX_W-1:0] sample = '0;
  logic             out_ready = 1'b0;
  logic             write_enable = 1'b0;
  logic             register_index = 1'b0;
  logic [CFG_W-1:0] write_data = '0;
  wire              in_ready;
  wire              out_valid;
  wire  [PIX_W-1:0] local_mean;
  wire              band_end;

  causal_neighbour_local_average DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .local_mean     (local_mean),
    .band_end       (band_end),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  always #6 clk = ~clk;

  // Predictor state: previous row, window and raster position.
  logic [PIX_W-1:0] line_mem [MAX_ROW_LEN];
  int               west_px = 0;
  int               nw_px = 0;
  int               col_pos = 0;
  int               row_pos = 0;
  logic [CFG_W-1:0] width_reg = IMAGE_WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = IMAGE_HEIGHT_RESET;

  // Queues between the stimulus, the sender and the result checker.
  px_item_t tx_fifo [$];
  mean_t    expected_means [$];
  dir_row_t dir_table [$];

  int       pushed_total = 0;
  int       accepted_total = 0;
  int       result_count = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  // Sender and receiver controls, set by the stimulus for each phase.
  int       tx_gap_max = 0;
  int       gap_left = 0;
  int       burst_left = 1;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_tick = 0;
  int       hold_asks = 0;
  int       hold_taken = 0;
  int       hold_len = 0;
  int       hold_left = 0;

  px_item_t tx_cur;
  mean_t    rx_got;
  logic [PIX_W-1:0] pred_mean;
  logic             pred_last;

  // Sizes in use after saturation of the register values.
  function automatic int sat_width(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_ROW_LEN) return MAX_ROW_LEN;
    return int'(v);
  endfunction

  function automatic int sat_height(input logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_ROWS) return MAX_ROWS;
    return int'(v);
  endfunction

  // Mean of the sample and its available causal neighbours; advances the raster.
  function automatic void filter_sample(input logic [PIX_W-1:0] s,
                                        output logic [PIX_W-1:0] mean,
                                        output logic last);
    int w;
    int h;
    int n;
    int ne;
    int q;
    bit lc;
    bit lr;
    w  = sat_width(width_reg);
    h  = sat_height(height_reg);
    lc = (col_pos >= w - 1);
    lr = (row_pos >= h - 1);
    n  = line_mem[col_pos];
    ne = (!lc && col_pos + 1 < MAX_ROW_LEN) ? line_mem[col_pos + 1] : 0;
    if (row_pos == 0) begin
      q = (col_pos == 0) ? int'(s) : (int'(s) + west_px) / 2;
    end else if (col_pos == 0) begin
      q = (int'(s) + n + ne) / 3;
    end else if (!lc) begin
      q = (int'(s) + west_px + nw_px + n + ne) / 5;
    end else begin
      q = (int'(s) + west_px + nw_px + n) / 4;
    end
    mean = PIX_W'(q);
    last = lc && lr;
    line_mem[col_pos] = s;
    nw_px   = n;
    west_px = int'(s);
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void add_px(input logic [PIX_W-1:0] s, input logic fixed,
                                 input logic [PIX_W-1:0] m, input logic e);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = 1'b0;
    r.value  = '0;
    r.item   = '{px: s, fixed: fixed, mean: m, last: e};
    dir_table.push_back(r);
  endfunction

  function automatic void add_cfg(input logic idx, input logic [CFG_W-1:0] v);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    r.item   = '0;
    dir_table.push_back(r);
  endfunction

  function automatic void offer(input px_item_t item);
    tx_fifo.push_back(item);
    pushed_total++;
  endfunction

  // Random samples, with the extremes favoured.
  function automatic void queue_random(input int count);
    px_item_t item;
    for (int i = 0; i < count; i++) begin
      item = '0;
      case ($urandom_range(0, 7))
        0: begin
          item.px = '0;
        end
        1: begin
          item.px = '1;
        end
        default: begin
          item.px = PIX_W'($urandom_range(0, 255));
        end
      endcase
      offer(item);
    end
  endfunction

  // Waits until every offered sample has been transferred and every result taken.
  task automatic wait_idle();
    while (accepted_total != pushed_total || expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] em,
                               input logic ee);
    if (mismatches < SHOWN_MISMATCHES)
      $display("mismatch at result %0d (%s): expected mean %0d end %0b, got mean %0d end %0b",
               result_count, what, em, ee, local_mean, band_end);
    mismatches++;
  endtask

  // Sender: predicts each transfer and offers samples in bursts with gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        filter_sample(tx_cur.px, pred_mean, pred_last);
        if (tx_cur.fixed) expected_means.push_back(mean_t'{mean: tx_cur.mean, last: tx_cur.last});
        else expected_means.push_back(mean_t'{mean: pred_mean, last: pred_last});
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_fifo.size() != 0) begin
          tx_cur = tx_fifo.pop_front();
          sample   <= tx_cur.px;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on its own pattern or a long hold.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          flag_mismatch("no result was expected", '0, 1'b0);
        end else begin
          rx_got = expected_means.pop_front();
          if (local_mean !== rx_got.mean || band_end !== rx_got.last)
            flag_mismatch("wrong value", rx_got.mean, rx_got.last);
        end
        result_count++;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_taken != hold_asks) begin
        hold_taken = hold_asks;
        hold_left  = hold_len;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: begin
            out_ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready <= ((rx_tick % 9) > 2);
          end
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || write_enable)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w_raw;
    logic [CFG_W-1:0] h_raw;
    int w;
    int h;
    int band;
    int n;
    int flush;
    int random_items;
    int phases;
    int directed_items;

    random_items = 0;
    phases = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table: start of band with the reset sizes, then saturated sizes,
    // a size shrunk under the current position, and every neighbourhood shape.
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd0,   1'b1, 8'd127, 1'b0);
    add_cfg(REG_IMAGE_WIDTH,  11'd1);
    add_cfg(REG_IMAGE_HEIGHT, 11'd0);
    add_px(8'd255, 1'b1, 8'd127, 1'b1);
    add_px(8'd200, 1'b1, 8'd200, 1'b0);
    add_px(8'd100, 1'b1, 8'd150, 1'b1);
    add_cfg(REG_IMAGE_WIDTH,  11'd2047);
    add_cfg(REG_IMAGE_HEIGHT, 11'd2047);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_cfg(REG_IMAGE_WIDTH,  11'd3);
    add_cfg(REG_IMAGE_HEIGHT, 11'd3);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd0,   1'b0, 8'd0,   1'b0);
    add_px(8'd0,   1'b0, 8'd0,   1'b0);
    add_px(8'd0,   1'b0, 8'd0,   1'b0);
    add_cfg(REG_IMAGE_WIDTH,  11'd1024);
    add_cfg(REG_IMAGE_HEIGHT, 11'd1);
    add_px(8'd255, 1'b1, 8'd255, 1'b0);
    add_px(8'd1,   1'b1, 8'd128, 1'b0);
    add_cfg(REG_IMAGE_WIDTH,  11'd2);
    add_cfg(REG_IMAGE_HEIGHT, 11'd1024);
    add_px(8'd10,  1'b1, 8'd5,   1'b0);
    add_px(8'd7,   1'b0, 8'd0,   1'b0);
    add_px(8'd9,   1'b0, 8'd0,   1'b0);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        wait_idle();
        write_reg(dir_table[i].idx, dir_table[i].value);
      end else begin
        offer(dir_table[i].item);
      end
    end
    wait_idle();
    directed_items = pushed_total;

    // Random phases: new sizes, then whole and partial bands of random samples.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          case ($urandom_range(0, 5))
            0: w_raw = 11'd0;
            1: w_raw = 11'd1;
            2: w_raw = 11'd2;
            3: w_raw = 11'd1024;
            4: w_raw = 11'd1025;
            default: w_raw = 11'd2047;
          endcase
        end
        1: begin
          w_raw = CFG_W'($urandom_range(13, 2047));
        end
        default: begin
          w_raw = CFG_W'($urandom_range(2, 12));
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: h_raw = 11'd0;
            1: h_raw = 11'd1;
            2: h_raw = 11'd1024;
            default: h_raw = 11'd2047;
          endcase
        end
        1: begin
          h_raw = CFG_W'($urandom_range(7, 2047));
        end
        default: begin
          h_raw = CFG_W'($urandom_range(1, 6));
        end
      endcase
      if (phases == 0) begin
        w_raw = CFG_W'($urandom_range(3, 8));
        h_raw = CFG_W'($urandom_range(2, 5));
      end

      // A wider row may only start on row zero, or the line buffer would be
      // read where it was never written: finish the current row first.
      if (sat_width(w_raw) > sat_width(width_reg) && row_pos != 0) begin
        write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 1)));
        flush = (col_pos >= sat_width(width_reg) - 1) ? 1 : sat_width(width_reg) - col_pos;
        queue_random(flush);
        random_items += flush;
        wait_idle();
      end

      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_IMAGE_WIDTH, w_raw);
        write_reg(REG_IMAGE_HEIGHT, h_raw);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, h_raw);
        write_reg(REG_IMAGE_WIDTH, w_raw);
      end

      w = sat_width(w_raw);
      h = sat_height(h_raw);
      band = w * h;
      if (band <= 256) begin
        n = band * $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 0) n += $urandom_range(0, band - 1);
      end else begin
        n = w + $urandom_range(1, 40);
      end

      case ($urandom_range(0, 3))
        0: tx_gap_max = 0;
        1: tx_gap_max = 2;
        2: tx_gap_max = 6;
        default: tx_gap_max = 15;
      endcase
      rx_mode = rx_mode_t'($urandom_range(0, 2));

      // Long receiver hold while the sender keeps offering, so the input stalls.
      if (phases == 0 || $urandom_range(0, 9) == 0) begin
        hold_len = $urandom_range(150, 400);
        hold_asks++;
        if (n < 40) n = 40;
      end

      queue_random(n);
      random_items += n;
      wait_idle();
      phases++;
    end

    wait_idle();
    $display("Covered %0d directed and %0d random sample transfers over %0d random size settings,",
             directed_items, random_items, phases);
    $display("including saturated sizes, sizes shrunk mid-band and long output stalls; %0d checked.",
             result_count);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
